FILE: design/wage_pkg.sv
// ----------------------------------------------------------------------------
// wage_pkg
// Shared types and constants for the weighted-age scheduler: field widths,
// command codes, sequencer states and the control bundles between modules.
// ----------------------------------------------------------------------------
package wage_pkg;

  // Default sizing
  localparam int USERS_DEF     = 8;
  localparam int TIME_BITS_DEF = 32;
  localparam int QLEN_BITS_DEF = 16;

  // Fixed port field widths
  localparam int USER_W      = 3;
  localparam int QIN_W       = 16;
  localparam int OUT_SCORE_W = 48;

  // Command codes carried in func
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_FIN
  } wage_state_e;

  // Control toward the per-user store
  typedef struct packed {
    logic rd_en;
    logic q_we;
    logic t_we;
  } wage_store_ctrl_t;

  // Control toward the multiply-compare unit
  typedef struct packed {
    logic lo_en;
    logic hi_en;
    logic cmp_en;
    logic clr;
  } wage_unit_ctrl_t;

endpackage

FILE: design/wage_store.sv
// ----------------------------------------------------------------------------
// wage_store
// Per-user queue lengths and last-served ticks. One read port shared by
// both arrays, registered read data, and a valid bit per entry so that an
// entry never written since reset reads as zero.
// ----------------------------------------------------------------------------
module wage_store #(
  parameter int USERS     = wage_pkg::USERS_DEF,
  parameter int TIME_BITS = wage_pkg::TIME_BITS_DEF,
  parameter int QLEN_BITS = wage_pkg::QLEN_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wage_pkg::wage_store_ctrl_t ctrl_i,
  input  logic [$clog2(USERS)-1:0]   rd_addr_i,
  input  logic [$clog2(USERS)-1:0]   q_waddr_i,
  input  logic [QLEN_BITS-1:0]       q_wdata_i,
  input  logic [$clog2(USERS)-1:0]   t_waddr_i,
  input  logic [TIME_BITS-1:0]       t_wdata_i,
  output logic [QLEN_BITS-1:0]       qlen_o,
  output logic [TIME_BITS-1:0]       last_o
);

  logic [QLEN_BITS-1:0] q_mem [USERS];
  logic [TIME_BITS-1:0] t_mem [USERS];
  logic [USERS-1:0]     q_vld_q;
  logic [USERS-1:0]     t_vld_q;
  logic [QLEN_BITS-1:0] q_rd_q;
  logic [TIME_BITS-1:0] t_rd_q;
  logic                 q_rv_q;
  logic                 t_rv_q;

  // Write ports and registered read data
  always_ff @(posedge clk_i) begin
    if (ctrl_i.q_we) begin
      q_mem[q_waddr_i] <= q_wdata_i;
    end
    if (ctrl_i.t_we) begin
      t_mem[t_waddr_i] <= t_wdata_i;
    end
    if (ctrl_i.rd_en) begin
      q_rd_q <= q_mem[rd_addr_i];
      t_rd_q <= t_mem[rd_addr_i];
    end
  end

  // Track written entries; reset clears them all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_vld_q <= '0;
      t_vld_q <= '0;
      q_rv_q  <= 1'b0;
      t_rv_q  <= 1'b0;
    end else begin
      if (ctrl_i.q_we) begin
        q_vld_q[q_waddr_i] <= 1'b1;
      end
      if (ctrl_i.t_we) begin
        t_vld_q[t_waddr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        q_rv_q <= q_vld_q[rd_addr_i];
        t_rv_q <= t_vld_q[rd_addr_i];
      end
    end
  end

  // Unwritten entries read as zero
  assign qlen_o = q_rv_q ? q_rd_q : '0;
  assign last_o = t_rv_q ? t_rd_q : '0;

endmodule

FILE: design/wage_unit.sv
// ----------------------------------------------------------------------------
// wage_unit
// Shared multiply-compare unit. Forms one user's score in two halves of the
// elapsed time, then compares it against the running best (strictly greater
// wins, so ties keep the lower index).
// ----------------------------------------------------------------------------
module wage_unit #(
  parameter int USERS     = wage_pkg::USERS_DEF,
  parameter int TIME_BITS = wage_pkg::TIME_BITS_DEF,
  parameter int QLEN_BITS = wage_pkg::QLEN_BITS_DEF
) (
  input  logic                           clk_i,
  input  wage_pkg::wage_unit_ctrl_t      ctrl_i,
  input  logic [TIME_BITS-1:0]           tick_i,
  input  logic [TIME_BITS-1:0]           last_i,
  input  logic [QLEN_BITS-1:0]           qlen_i,
  input  logic [$clog2(USERS)-1:0]       idx_i,
  output logic [$clog2(USERS)-1:0]       win_idx_o,
  output logic [TIME_BITS+QLEN_BITS-1:0] win_score_o
);

  localparam int IDX_W   = $clog2(USERS);
  localparam int HALF    = (TIME_BITS + 1) / 2;
  localparam int HI_W    = TIME_BITS - HALF;
  localparam int SCORE_W = TIME_BITS + QLEN_BITS;
  localparam int PLO_W   = HALF + QLEN_BITS;
  localparam int PHI_W   = HI_W + QLEN_BITS;

  logic [TIME_BITS-1:0] elapsed;
  logic [PLO_W-1:0]     plo_d;
  logic [PLO_W-1:0]     plo_q;
  logic [HI_W-1:0]      el_hi_q;
  logic [QLEN_BITS-1:0] qlen_q;
  logic [IDX_W-1:0]     cur_idx_q;
  logic [PHI_W-1:0]     phi;
  logic [SCORE_W-1:0]   score_d;
  logic [SCORE_W-1:0]   score_q;
  logic [IDX_W-1:0]     score_idx_q;
  logic [SCORE_W-1:0]   best_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic                 greater;

  // Low half: elapsed time and the first partial product
  assign elapsed = tick_i - last_i;
  assign plo_d   = PLO_W'(elapsed[HALF-1:0]) * PLO_W'(qlen_i);

  // High half: second partial product, shifted and added
  assign phi     = PHI_W'(el_hi_q) * PHI_W'(qlen_q);
  assign score_d = {phi, {HALF{1'b0}}} + SCORE_W'(plo_q);

  // Compare against the running best
  assign greater     = score_q > best_q;
  assign win_idx_o   = greater ? score_idx_q : best_idx_q;
  assign win_score_o = greater ? score_q : best_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.lo_en) begin
      plo_q     <= plo_d;
      el_hi_q   <= elapsed[TIME_BITS-1:HALF];
      qlen_q    <= qlen_i;
      cur_idx_q <= idx_i;
    end
    if (ctrl_i.hi_en) begin
      score_q     <= score_d;
      score_idx_q <= cur_idx_q;
    end
    if (ctrl_i.clr) begin
      best_q     <= '0;
      best_idx_q <= '0;
    end else if (ctrl_i.cmp_en) begin
      best_q     <= win_score_o;
      best_idx_q <= win_idx_o;
    end
  end

endmodule

FILE: design/weighted_age_scheduler.sv
// Update transaction: stored at once on accept, no result.
// Tick transaction: the sequencer scans the users in order, taking each through
// S_LO then S_HI in the shared multiply-compare unit, and loads the result in S_FIN.
// Input is stalled from tick accept until the result is loaded, so no new tick is
// taken during a scan; the load also waits on a full output register.
// Reset clears the tick counter, sequencer and all per-entry valid bits at once.
// ----------------------------------------------------------------------------
// weighted_age_scheduler
// Max-weight scheduler: each tick grants the user with the greatest
// (elapsed ticks x queue length), ties to the lowest index.
// ----------------------------------------------------------------------------
module weighted_age_scheduler #(
  parameter int USERS     = wage_pkg::USERS_DEF,
  parameter int TIME_BITS = wage_pkg::TIME_BITS_DEF,
  parameter int QLEN_BITS = wage_pkg::QLEN_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             func_i,
  input  logic [wage_pkg::USER_W-1:0]      user_i,
  input  logic [wage_pkg::QIN_W-1:0]       queue_length_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [wage_pkg::USER_W-1:0]      granted_user_o,
  output logic [wage_pkg::OUT_SCORE_W-1:0] winning_score_o
);

  localparam int IDX_W   = $clog2(USERS);
  localparam int SCORE_W = TIME_BITS + QLEN_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(USERS - 1);
  localparam longint unsigned QMAX = (64'd1 << QLEN_BITS) - 64'd1;

  wage_pkg::wage_state_e      state_q, state_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [TIME_BITS-1:0]       tick_q;
  logic                       out_valid_q;
  logic [wage_pkg::USER_W-1:0]      granted_q;
  logic [wage_pkg::OUT_SCORE_W-1:0] score_out_q;

  logic                       in_acc;
  logic                       tick_acc;
  logic                       user_ok;
  logic                       out_free;
  logic                       out_load;
  logic [QLEN_BITS-1:0]       q_wdata;
  logic [IDX_W-1:0]           rd_addr;
  wage_pkg::wage_store_ctrl_t store_ctrl;
  wage_pkg::wage_unit_ctrl_t  unit_ctrl;
  logic [QLEN_BITS-1:0]       qlen;
  logic [TIME_BITS-1:0]       last;
  logic [IDX_W-1:0]           win_idx;
  logic [SCORE_W-1:0]         win_score;

  // Handshake decode
  assign in_stall_o = (state_q != wage_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tick_acc   = in_acc && (func_i == wage_pkg::FUNC_TICK);
  assign user_ok    = 32'(user_i) < USERS;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == wage_pkg::S_FIN) && out_free;

  // Saturate the incoming queue length to the stored width
  assign q_wdata = (64'(queue_length_i) > QMAX) ? '1 : QLEN_BITS'(queue_length_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wage_pkg::S_IDLE: begin
        if (tick_acc) state_d = wage_pkg::S_LO;
      end
      wage_pkg::S_LO: begin
        state_d = wage_pkg::S_HI;
      end
      wage_pkg::S_HI: begin
        state_d = (idx_q == LAST_IDX) ? wage_pkg::S_FIN : wage_pkg::S_LO;
      end
      wage_pkg::S_FIN: begin
        if (out_free) state_d = wage_pkg::S_IDLE;
      end
      default: state_d = wage_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    idx_d      = idx_q;
    rd_addr    = idx_q + IDX_W'(1);
    store_ctrl = '0;
    unit_ctrl  = '0;
    unique case (state_q)
      wage_pkg::S_IDLE: begin
        rd_addr          = '0;
        store_ctrl.rd_en = tick_acc;
        store_ctrl.q_we  = in_acc && (func_i == wage_pkg::FUNC_UPDATE) && user_ok;
        unit_ctrl.clr    = tick_acc;
        if (tick_acc) idx_d = '0;
      end
      wage_pkg::S_LO: begin
        unit_ctrl.lo_en  = 1'b1;
        unit_ctrl.cmp_en = (idx_q != '0);
      end
      wage_pkg::S_HI: begin
        unit_ctrl.hi_en  = 1'b1;
        store_ctrl.rd_en = (idx_q != LAST_IDX);
        if (idx_q != LAST_IDX) idx_d = idx_q + IDX_W'(1);
      end
      wage_pkg::S_FIN: begin
        store_ctrl.t_we = out_free;
      end
      default: ;
    endcase
  end

  // Sequencer, tick counter and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wage_pkg::S_IDLE;
      idx_q       <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (out_load) begin
        tick_q      <= tick_q + TIME_BITS'(1);
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until it is taken
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      granted_q   <= wage_pkg::USER_W'(win_idx);
      score_out_q <= wage_pkg::OUT_SCORE_W'(win_score);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_user_o  = granted_q;
  assign winning_score_o = score_out_q;

  wage_store #(
    .USERS     (USERS),
    .TIME_BITS (TIME_BITS),
    .QLEN_BITS (QLEN_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (store_ctrl),
    .rd_addr_i (rd_addr),
    .q_waddr_i (IDX_W'(user_i)),
    .q_wdata_i (q_wdata),
    .t_waddr_i (win_idx),
    .t_wdata_i (tick_q),
    .qlen_o    (qlen),
    .last_o    (last)
  );

  wage_unit #(
    .USERS     (USERS),
    .TIME_BITS (TIME_BITS),
    .QLEN_BITS (QLEN_BITS)
  ) u_unit (
    .clk_i       (clk_i),
    .ctrl_i      (unit_ctrl),
    .tick_i      (tick_q),
    .last_i      (last),
    .qlen_i      (qlen),
    .idx_i       (idx_q),
    .win_idx_o   (win_idx),
    .win_score_o (win_score)
  );

  // Scan must have covered every user before the grant
  a_scan_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wage_pkg::S_FIN |-> idx_q == LAST_IDX)
    else $error("grant reached before scan finished");

  // An update transaction never starts a scan
  a_update_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && func_i == wage_pkg::FUNC_UPDATE) |=> state_q == wage_pkg::S_IDLE)
    else $error("update transaction left idle");

  // Each grant advances the tick counter by exactly one
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_o && tick_q == $past(tick_q) + TIME_BITS'(1)))
    else $error("tick counter out of step with grants");

endmodule

FILE: tb/weighted_age_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_age_scheduler_test
// Self-checking bench for the weighted-age scheduler. A scoreboard keeps its
// own copy of queue lengths, last-served ticks and the tick counter, predicts
// the grant for every accepted tick and compares it with the block's output.
// Stimulus is a short directed set (ties, all-zero scores, field extremes)
// followed by random updates and ticks sent in bursts against a stalling sink.
// ----------------------------------------------------------------------------
module weighted_age_scheduler_test;

  localparam int NUM_USERS    = wage_pkg::USERS_DEF;
  localparam int TIME_W       = wage_pkg::TIME_BITS_DEF;
  localparam int QLEN_W       = wage_pkg::QLEN_BITS_DEF;
  localparam int USER_W       = wage_pkg::USER_W;
  localparam int SCORE_W      = wage_pkg::OUT_SCORE_W;
  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [USER_W-1:0]  user;
    logic [SCORE_W-1:0] score;
  } grant_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_RUNS
  } stall_mode_e;

  // Scoreboard: mirrors the scheduler state and queues the expected grants
  class grant_tracker;
    logic [QLEN_W-1:0] qlen_tab [NUM_USERS];
    logic [TIME_W-1:0] served_at [NUM_USERS];
    logic [TIME_W-1:0] tick_now;
    grant_t            pending_grants [$];
    int unsigned       mismatches;
    int unsigned       updates_seen;
    int unsigned       ticks_seen;
    int unsigned       grants_checked;

    function new();
      foreach (qlen_tab[i]) begin
        qlen_tab[i]  = '0;
        served_at[i] = '0;
      end
      tick_now       = '0;
      mismatches     = 0;
      updates_seen   = 0;
      ticks_seen     = 0;
      grants_checked = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%0t: %s", $time, msg);
      end
    endfunction

    // Note an accepted input transaction; a tick queues its predicted grant
    function void note_request(logic f, logic [USER_W-1:0] u, logic [QLEN_W-1:0] q);
      grant_t             best;
      logic [TIME_W-1:0]  elapsed;
      logic [SCORE_W-1:0] score;
      int                 best_idx;
      if (f == wage_pkg::FUNC_UPDATE) begin
        qlen_tab[u] = q;
        updates_seen++;
        return;
      end
      ticks_seen++;
      best_idx   = 0;
      best.score = '0;
      // Strictly greater wins, so ties and all-zero scores stay on the lowest index
      for (int i = 0; i < NUM_USERS; i++) begin
        elapsed = tick_now - served_at[i];
        score   = SCORE_W'(elapsed) * SCORE_W'(qlen_tab[i]);
        if (score > best.score) begin
          best.score = score;
          best_idx   = i;
        end
      end
      best.user           = best_idx[USER_W-1:0];
      served_at[best_idx] = tick_now;
      // Counter wraps modulo 2^TIME_W through the vector width
      tick_now            = tick_now + 1'b1;
      pending_grants.push_back(best);
    endfunction

    // Compare one accepted result transaction with the oldest expected grant
    function void check_grant(logic [USER_W-1:0] u, logic [SCORE_W-1:0] s);
      grant_t want;
      if (pending_grants.size() == 0) begin
        flag($sformatf("unexpected grant: user %0d score %0d", u, s));
        return;
      end
      want = pending_grants.pop_front();
      grants_checked++;
      if (u !== want.user) begin
        flag($sformatf("granted_user: expected %0d, actual %0d", want.user, u));
      end
      if (s !== want.score) begin
        flag($sformatf("winning_score: expected %0d, actual %0d", want.score, s));
      end
    endfunction
  endclass

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               in_valid   = 1'b0;
  logic               func       = wage_pkg::FUNC_UPDATE;
  logic [USER_W-1:0]  user       = '0;
  logic [QLEN_W-1:0]  qlen       = '0;
  logic               out_stall  = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [USER_W-1:0]  granted_user_o;
  logic [SCORE_W-1:0] winning_score_o;

  stall_mode_e        stall_mode = STALL_NONE;
  int unsigned        stall_left = 0;
  grant_tracker       tracker;

  weighted_age_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .func_i          (func),
    .user_i          (user),
    .queue_length_i  (qlen),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .granted_user_o  (granted_user_o),
    .winning_score_o (winning_score_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Drive one input transaction from a falling edge and hold it until accepted
  task automatic send_item(input logic f, input logic [USER_W-1:0] u,
                           input logic [QLEN_W-1:0] q);
    in_valid <= 1'b1;
    func     <= f;
    user     <= u;
    qlen     <= q;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tracker.note_request(f, u, q);
    @(negedge clk_i);
  endtask

  // Drop valid for a gap between bursts
  task automatic idle_sender(input int unsigned cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  // Favor the extremes and tiny values so ties and large scores both show up
  function automatic logic [QLEN_W-1:0] pick_qlen();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return QLEN_W'($urandom_range(0, 3));
      default: return QLEN_W'($urandom_range(0, (1 << QLEN_W) - 1));
    endcase
  endfunction

  // Stall the result side in phases: none, scattered, or in runs
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      default:      out_stall <= ((stall_left % 8) < 5);
    endcase
  end

  // Check every accepted result transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall) begin
      tracker.check_grant(granted_user_o, winning_score_o);
    end
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned burst_left;
    logic        f;
    tracker    = new();
    burst_left = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // All scores zero: user 0 wins; unused fields at their maximum
    send_item(wage_pkg::FUNC_TICK, 3'd7, 16'hFFFF);
    // Equal full queues everywhere: ties go to the lowest index
    for (int u = 0; u < NUM_USERS; u++) begin
      send_item(wage_pkg::FUNC_UPDATE, USER_W'(u), 16'hFFFF);
    end
    send_item(wage_pkg::FUNC_TICK, 3'd0, 16'h0000);
    send_item(wage_pkg::FUNC_TICK, 3'd5, 16'h5555);
    // Mixed weights with alternating bit patterns, empty and minimal queues
    send_item(wage_pkg::FUNC_UPDATE, 3'd3, 16'h0000);
    send_item(wage_pkg::FUNC_UPDATE, 3'd7, 16'h0001);
    send_item(wage_pkg::FUNC_UPDATE, 3'd5, 16'hAAAA);
    send_item(wage_pkg::FUNC_UPDATE, 3'd6, 16'h5555);
    send_item(wage_pkg::FUNC_UPDATE, 3'd2, 16'h8000);
    repeat (3) send_item(wage_pkg::FUNC_TICK, 3'd2, 16'hAAAA);

    // Random updates and ticks in bursts with gaps of varied length
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24));
        burst_left = $urandom_range(1, 24);
      end
      burst_left = burst_left - 1;
      f = ($urandom_range(0, 9) < 4) ? wage_pkg::FUNC_TICK : wage_pkg::FUNC_UPDATE;
      send_item(f, USER_W'($urandom_range(0, NUM_USERS - 1)), pick_qlen());
    end
    in_valid <= 1'b0;

    // Wait for every outstanding grant, then let the pipeline settle
    while (tracker.pending_grants.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d queue updates and %0d ticks; %0d grants compared.",
             tracker.updates_seen, tracker.ticks_seen, tracker.grants_checked);
    $display("Mismatching fields or stray grants: %0d.", tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/wage_pkg.sv
design/wage_store.sv
design/wage_unit.sv
design/weighted_age_scheduler.sv
tb/weighted_age_scheduler_test.sv
